/* hw/rtl/mialu_pkg.sv */
`default_nettype none
package mialu_pkg;
	localparam int unsigned DataWidthDefault = 32;
	localparam int unsigned IoWidth = 32;
	localparam int unsigned OpWidth = 3;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_GCD  = 3'd5,
		OP_FACT = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL_W,
		ST_DIV_GO,
		ST_DIV_W,
		ST_POW_SQ,
		ST_POW_SQ_W,
		ST_POW_ML,
		ST_POW_ML_W,
		ST_GCD_CHK,
		ST_GCD_W,
		ST_FACT_CHK,
		ST_FACT_W,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic signed_div;
	} div_ctl_t;
endpackage
`default_nettype wire

/* hw/rtl/mialu_mul.sv */
`default_nettype none
// Shared multiplier, W x W low half, one registered product.
module mialu_mul #(
	parameter int unsigned DATA_WIDTH = mialu_pkg::DataWidthDefault
) (
	input  wire logic                  clk,
	input  wire logic [DATA_WIDTH-1:0] x,
	input  wire logic [DATA_WIDTH-1:0] y,
	output logic      [DATA_WIDTH-1:0] p
);
	logic [DATA_WIDTH-1:0] p_q;
	always_ff @(posedge clk) begin
		p_q <= x * y;
	end
	assign p = p_q;
endmodule
`default_nettype wire

/* hw/rtl/mialu_div.sv */
`default_nettype none
// Radix-2 restoring divider, one quotient bit per cycle, truncating.
module mialu_div #(
	parameter int unsigned DATA_WIDTH = mialu_pkg::DataWidthDefault
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mialu_pkg::div_ctl_t   ctl,
	input  wire logic [DATA_WIDTH-1:0] num,
	input  wire logic [DATA_WIDTH-1:0] den,
	output logic                       done,
	output logic      [DATA_WIDTH-1:0] quo,
	output logic      [DATA_WIDTH-1:0] rem
);
	localparam int unsigned CW = $clog2(DATA_WIDTH + 1);
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic [DATA_WIDTH-1:0] q_q, r_q, d_q;
	logic                  nq_q, nr_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH-1:0] nmag, dmag;

	assign nmag  = num[DATA_WIDTH-1] ? -num : num;
	assign dmag  = den[DATA_WIDTH-1] ? -den : den;
	assign trial = {r_q, q_q[DATA_WIDTH-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q  <= nmag;
			r_q  <= '0;
			d_q  <= dmag;
			nq_q <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
			nr_q <= num[DATA_WIDTH-1];
		end else if (busy_q) begin
			if (!trial[DATA_WIDTH]) begin
				r_q <= trial[DATA_WIDTH-1:0];
				q_q <= {q_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				r_q <= {r_q[DATA_WIDTH-2:0], q_q[DATA_WIDTH-1]};
				q_q <= {q_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quo = (ctl.signed_div && nq_q) ? -q_q : q_q;
	assign rem = nr_q ? -r_q : r_q;
endmodule
`default_nettype wire

/* hw/rtl/multi_op_integer_alu.sv */
`default_nettype none
// Channel | Signals                                  | Beat
// in      | start, busy, operation, operand_a/_b     | start & !busy
// out     | done, result, error                      | done (one cycle)
//
// Add and subtract go from the start beat straight to ST_DONE; multiply
// passes through ST_MUL and ST_MUL_W first. Divide yields one quotient bit
// per cycle. Power uses square-and-multiply on the shared multiplier. GCD
// runs one divider pass per Euclid step; factorial one multiply per term
// until k > n or the product wraps to zero. Reset clears the sequencer only.
// The receiver cannot stall; busy stays high up to and including the done beat.
module multi_op_integer_alu #(
	parameter int unsigned DATA_WIDTH = mialu_pkg::DataWidthDefault
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [mialu_pkg::OpWidth-1:0] operation,
	input  wire logic signed [mialu_pkg::IoWidth-1:0] operand_a,
	input  wire logic signed [mialu_pkg::IoWidth-1:0] operand_b,
	output logic                              done,
	output logic signed [mialu_pkg::IoWidth-1:0] result,
	output logic                              error
);
	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned IW = mialu_pkg::IoWidth;

	mialu_pkg::state_t state_q, state_d;
	mialu_pkg::op_t    op_q;
	logic [W-1:0] a_q, b_q, acc_q;	// working operands, accumulator
	logic [W-1:0] mx, my, mp;
	logic [W-1:0] quo, rem;
	logic         div_done;
	mialu_pkg::div_ctl_t dctl;
	logic [W-1:0] a_ext, b_ext;
	logic [W-1:0] res_q;
	logic         err_q, done_q;
	logic         accept;	// input beat: start seen while not busy

	// sign-extend or truncate the 32-bit ports to working width
	function automatic logic [W-1:0] ext(input logic [IW-1:0] v);
		logic [W+IW-1:0] t;
		t = {{W{v[IW-1]}}, v};
		return t[W-1:0];
	endfunction

	// working width back to the 32-bit result port, sign-extended
	function automatic logic [IW-1:0] to_io(input logic [W-1:0] v);
		logic [W+IW-1:0] t;
		t = {{IW{v[W-1]}}, v};
		return t[IW-1:0];
	endfunction

	assign a_ext  = ext(operand_a);
	assign b_ext  = ext(operand_b);
	assign accept = start && !busy;

	mialu_mul #(.DATA_WIDTH(W)) u_mul (.clk(clk), .x(mx), .y(my), .p(mp));
	mialu_div #(.DATA_WIDTH(W)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(a_q), .den(b_q),
		.done(div_done), .quo(quo), .rem(rem)
	);

	// multiplier operand steering
	always_comb begin
		mx = a_q;
		my = b_q;
		unique case (state_q)
			mialu_pkg::ST_POW_SQ:  begin mx = a_q;   my = a_q; end
			mialu_pkg::ST_POW_ML:  begin mx = acc_q; my = a_q; end
			mialu_pkg::ST_FACT_CHK: begin mx = acc_q; my = b_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mialu_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// next state and divider kick
	always_comb begin
		state_d = state_q;
		dctl.start = 1'b0;
		dctl.signed_div = (op_q == mialu_pkg::OP_DIV);
		unique case (state_q)
			mialu_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (mialu_pkg::op_t'(operation))
						mialu_pkg::OP_MUL:  state_d = mialu_pkg::ST_MUL;
						mialu_pkg::OP_DIV:  state_d = (b_ext == '0) ?
							mialu_pkg::ST_DONE : mialu_pkg::ST_DIV_GO;
						mialu_pkg::OP_POW:  state_d = mialu_pkg::ST_POW_ML;
						mialu_pkg::OP_GCD:  state_d = mialu_pkg::ST_GCD_CHK;
						mialu_pkg::OP_FACT: state_d = mialu_pkg::ST_FACT_CHK;
						default:            state_d = mialu_pkg::ST_DONE;
					endcase
				end
			end
			mialu_pkg::ST_MUL:   state_d = mialu_pkg::ST_MUL_W;
			mialu_pkg::ST_MUL_W: state_d = mialu_pkg::ST_DONE;
			mialu_pkg::ST_DIV_GO: begin
				dctl.start = 1'b1;
				state_d = mialu_pkg::ST_DIV_W;
			end
			mialu_pkg::ST_DIV_W: if (div_done) state_d = mialu_pkg::ST_DONE;
			// b_q holds remaining exponent; multiply in when low bit set
			mialu_pkg::ST_POW_ML: begin
				if (b_q == '0 || b_q[W-1]) state_d = mialu_pkg::ST_DONE;
				else if (b_q[0])           state_d = mialu_pkg::ST_POW_ML_W;
				else                       state_d = mialu_pkg::ST_POW_SQ;
			end
			mialu_pkg::ST_POW_ML_W: state_d = mialu_pkg::ST_POW_SQ;
			mialu_pkg::ST_POW_SQ:   state_d = mialu_pkg::ST_POW_SQ_W;
			mialu_pkg::ST_POW_SQ_W: state_d = mialu_pkg::ST_POW_ML;
			mialu_pkg::ST_GCD_CHK: begin
				if (b_q == '0) state_d = mialu_pkg::ST_DONE;
				else begin
					dctl.start = 1'b1;
					state_d = mialu_pkg::ST_GCD_W;
				end
			end
			mialu_pkg::ST_GCD_W: if (div_done) state_d = mialu_pkg::ST_GCD_CHK;
			// b_q is k, a_q is n; stop on error (negative n), when k > n or product wrapped to zero
			mialu_pkg::ST_FACT_CHK: begin
				if (err_q || b_q > a_q || acc_q == '0) state_d = mialu_pkg::ST_DONE;
				else state_d = mialu_pkg::ST_FACT_W;
			end
			mialu_pkg::ST_FACT_W: state_d = mialu_pkg::ST_FACT_CHK;
			mialu_pkg::ST_DONE:   state_d = mialu_pkg::ST_IDLE;
			default:              state_d = mialu_pkg::ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			mialu_pkg::ST_IDLE: if (accept) begin
				op_q  <= mialu_pkg::op_t'(operation);
				a_q   <= a_ext;
				b_q   <= b_ext;
				acc_q <= W'(1);
				err_q <= 1'b0;
				res_q <= '0;
				unique case (mialu_pkg::op_t'(operation))
					mialu_pkg::OP_ADD: res_q <= a_ext + b_ext;
					mialu_pkg::OP_SUB: res_q <= a_ext - b_ext;
					mialu_pkg::OP_DIV: err_q <= (b_ext == '0);
					mialu_pkg::OP_GCD: if ($signed(a_ext) < $signed(b_ext)) begin
						a_q <= b_ext;
						b_q <= a_ext;
					end
					mialu_pkg::OP_FACT: begin
						err_q <= a_ext[W-1];
						b_q   <= W'(2);
					end
					default: ;
				endcase
			end
			mialu_pkg::ST_MUL_W: res_q <= mp;
			mialu_pkg::ST_DIV_W: if (div_done) res_q <= quo;
			mialu_pkg::ST_POW_ML: begin
				if (b_q == '0 || b_q[W-1]) res_q <= acc_q;
			end
			mialu_pkg::ST_POW_ML_W: acc_q <= mp;
			mialu_pkg::ST_POW_SQ_W: begin
				a_q <= mp;
				b_q <= {1'b0, b_q[W-1:1]};
			end
			mialu_pkg::ST_GCD_CHK: if (b_q == '0) res_q <= a_q;
			mialu_pkg::ST_GCD_W: if (div_done) begin
				a_q <= b_q;
				b_q <= rem;
			end
			mialu_pkg::ST_FACT_CHK: begin
				if (!err_q && (b_q > a_q || acc_q == '0)) res_q <= acc_q;
			end
			mialu_pkg::ST_FACT_W: begin
				acc_q <= mp;
				b_q   <= b_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= (state_q == mialu_pkg::ST_DONE);
	end

	assign busy   = (state_q != mialu_pkg::ST_IDLE) || done_q;
	assign done   = done_q;
	assign result = err_q ? '0 : to_io(res_q);
	assign error  = err_q;
endmodule
`default_nettype wire
